FILE: hdl/aehr_pkg.sv
// Shared types and command codes for the access event history ring.
`timescale 1ns / 1ps
`default_nettype none
package aehr_pkg;

  localparam int HELD_W = 5;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_LIST   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        user_kind;
    logic [1:0]  place;
    logic [31:0] card_uid;
  } req_t;

  typedef struct packed {
    logic              entry_kind;
    logic [1:0]        entry_place;
    logic [31:0]       entry_uid;
    logic [HELD_W-1:0] entries_held;
    logic              empty_res;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  place;
    logic [31:0] uid;
  } entry_t;

endpackage
`default_nettype wire

FILE: hdl/access_event_history_ring_core.sv
// Access event history ring: circular log of recent access events in one memory.
//
// Channels: req (req_valid/req_ready/req) carries commands, rsp (rsp_valid/
// rsp_ready/rsp) carries results; a transfer happens when valid and ready are
// both high at a rising edge of clk.
// Record, clear and the unused command give one result, registered in the cycle
// after the transfer. A list with entries held walks the ring from oldest to
// newest: each entry is read into the read stage and then moved to the output
// register, one entry per cycle while rsp_ready is high, paced by the single
// registered read port of the entry memory. The final result of each command
// has last set; an empty list gives one result with empty_res set.
// A command is taken when the walker is idle and the output register is free
// or being emptied in the same cycle, so record and clear can be taken back to
// back while rsp_ready is high; a list blocks commands until its last entry
// moves to the output register. When rsp_ready is low the output register and
// the read stage hold, and the walker pauses; nothing is dropped.
// Reset (rst, synchronous) empties the log and clears rsp_valid.
// The entry memory is not cleared; only written slots are ever read.
`timescale 1ns / 1ps
`default_nettype none
module access_event_history_ring_core
  import aehr_pkg::*;
#(
  parameter int DEPTH = 20
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  wire  rsp_ready,
  output rsp_t rsp
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [PW-1:0]  oldest;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  remaining;
  logic           p_valid;
  logic           p_last;
  entry_t         mem [DEPTH];
  entry_t         mem_q;

  logic           acc;
  logic           out_free;
  logic           move;
  logic           issue;
  logic           full;
  logic           rec_we;
  logic           list_go;
  logic [PW-1:0]  wr_slot;
  logic [CW-1:0]  count_next;
  logic [PW-1:0]  oldest_next;
  entry_t         wr_entry;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && out_free;
  assign acc       = req_valid && req_ready;
  assign move      = p_valid && out_free;
  assign issue     = (state == ST_LIST) && (remaining != '0) && (!p_valid || move);

  assign full        = (count == FULL_CNT);
  assign wr_slot     = full ? oldest : count[PW-1:0];
  assign count_next  = full ? count : count + 1'b1;
  assign oldest_next = full ? wrap_inc(oldest) : oldest;
  assign rec_we      = acc && (req.cmd == CMD_RECORD);
  assign list_go     = acc && (req.cmd == CMD_LIST) && (count != '0);
  assign wr_entry    = '{kind: req.user_kind, place: req.place, uid: req.card_uid};

  always_ff @(posedge clk) begin
    if (rec_we) begin
      mem[wr_slot] <= wr_entry;
    end
    if (issue) begin
      mem_q <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      oldest    <= '0;
      rd_ptr    <= '0;
      remaining <= '0;
      p_valid   <= 1'b0;
      p_last    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= move || (acc && !list_go) || (rsp_valid && !rsp_ready);

      if (acc) begin
        unique case (req.cmd)
          CMD_RECORD: begin
            count  <= count_next;
            oldest <= oldest_next;
            rsp    <= '{entries_held: HELD_W'(count_next), last: 1'b1, default: '0};
          end
          CMD_LIST: begin
            if (count == '0) begin
              rsp <= '{empty_res: 1'b1, last: 1'b1, default: '0};
            end else begin
              state     <= ST_LIST;
              rd_ptr    <= oldest;
              remaining <= count;
            end
          end
          CMD_CLEAR: begin
            count  <= '0;
            oldest <= '0;
            rsp    <= '{last: 1'b1, default: '0};
          end
          default: begin
            rsp <= '{entries_held: HELD_W'(count), last: 1'b1, default: '0};
          end
        endcase
      end

      if (issue) begin
        rd_ptr    <= wrap_inc(rd_ptr);
        remaining <= remaining - 1'b1;
        p_valid   <= 1'b1;
        p_last    <= (remaining == CW'(1));
      end else if (move) begin
        p_valid <= 1'b0;
      end

      if (move) begin
        rsp <= '{entry_kind: mem_q.kind, entry_place: mem_q.place, entry_uid: mem_q.uid,
                 entries_held: HELD_W'(count), empty_res: 1'b0, last: p_last};
        if (p_last) begin
          state <= ST_IDLE;
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest != '0) |-> full)
    else $error("oldest pointer moved before ring filled");

  a_stage_in_list: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> (state == ST_LIST))
    else $error("read stage busy outside list walk");

  a_list_starts: assert property (@(posedge clk) disable iff (rst)
    (acc && (req.cmd == CMD_LIST) && (count != '0)) |=> (state == ST_LIST) && !rsp_valid)
    else $error("list with entries did not start walk");

  a_walk_no_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (state == ST_LIST)) |-> !rsp.empty_res)
    else $error("empty flag during list walk");

endmodule
`default_nettype wire
